// ----- hdl/pidz_pkg.sv -----
// ----------------------------------------------------------------------------
// pidz_pkg
// Widths, register indexes, reset values and the configuration bundle of the
// position PID with integral zone.
// ----------------------------------------------------------------------------
package pidz_pkg;

  localparam int POS_W    = 24;           // measured and target position
  localparam int ERR_W    = POS_W + 1;    // target minus position, exact
  localparam int DER_W    = ERR_W + 1;    // error minus previous error
  localparam int INT_W    = 22;           // integral accumulator
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 8;            // Q8.8 gains
  localparam int OLIM_W   = 7;
  localparam int ILIM_W   = 20;
  localparam int ZONE_W   = 16;
  localparam int DRIVE_W  = 8;

  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + INT_W;
  localparam int PROD_D_W = GAIN_W + 1 + DER_W;
  localparam int ACC_W    = PROD_D_W + 1;
  localparam int SHR_W    = ACC_W - FRAC_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_THR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd7;

  // reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd346;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd56;
  localparam logic [OLIM_W-1:0] OUT_LIMIT_RST = 7'd127;
  localparam logic [ILIM_W-1:0] INT_LIMIT_RST = 20'hFFFFF;
  localparam logic [ZONE_W-1:0] ZONE_RST      = 16'd15;
  localparam logic [ZONE_W-1:0] EXIT_THR_RST  = 16'd0;
  localparam logic [POS_W-1:0]  TARGET_RST    = 24'd0;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [OLIM_W-1:0]       output_limit;
    logic [ILIM_W-1:0]       integral_limit;
    logic [ZONE_W-1:0]       integ_zone;
    logic [ZONE_W-1:0]       exit_threshold;
    logic signed [POS_W-1:0] target_position;
  } cfg_t;

endpackage

// ----- hdl/pidz_sample_if.sv -----
// ----------------------------------------------------------------------------
// pidz_sample_if
// Position sample channel.
// ----------------------------------------------------------------------------
interface pidz_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [pidz_pkg::POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

// ----- hdl/pidz_result_if.sv -----
// ----------------------------------------------------------------------------
// pidz_result_if
// Drive result channel.
// ----------------------------------------------------------------------------
interface pidz_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidz_pkg::DRIVE_W-1:0] drive;
  logic                               at_target;
  logic signed [pidz_pkg::ERR_W-1:0]   error_value;

  modport source (output valid, output drive, output at_target, output error_value,
                  input ready);
  modport sink (input valid, input drive, input at_target, input error_value,
                output ready);
endinterface

// ----- hdl/pidz_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pidz_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface pidz_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pidz_pkg::CFG_IDX_W-1:0]     index;
  logic [pidz_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/pidz_regs.sv -----
// ----------------------------------------------------------------------------
// pidz_regs
// Configuration register file; takes one write word per cycle.
// ----------------------------------------------------------------------------
module pidz_regs (
  input  logic               clk,
  input  logic               rst,
  pidz_cfg_if.sink           cfg,
  output pidz_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_p          <= pidz_pkg::GAIN_P_RST;
      regs.gain_i          <= pidz_pkg::GAIN_I_RST;
      regs.gain_d          <= pidz_pkg::GAIN_D_RST;
      regs.output_limit    <= pidz_pkg::OUT_LIMIT_RST;
      regs.integral_limit  <= pidz_pkg::INT_LIMIT_RST;
      regs.integ_zone      <= pidz_pkg::ZONE_RST;
      regs.exit_threshold  <= pidz_pkg::EXIT_THR_RST;
      regs.target_position <= pidz_pkg::TARGET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pidz_pkg::REG_GAIN_P:    regs.gain_p <= cfg.data[pidz_pkg::GAIN_W-1:0];
        pidz_pkg::REG_GAIN_I:    regs.gain_i <= cfg.data[pidz_pkg::GAIN_W-1:0];
        pidz_pkg::REG_GAIN_D:    regs.gain_d <= cfg.data[pidz_pkg::GAIN_W-1:0];
        pidz_pkg::REG_OUT_LIMIT: regs.output_limit <= cfg.data[pidz_pkg::OLIM_W-1:0];
        pidz_pkg::REG_INT_LIMIT: regs.integral_limit <= cfg.data[pidz_pkg::ILIM_W-1:0];
        pidz_pkg::REG_ZONE:      regs.integ_zone <= cfg.data[pidz_pkg::ZONE_W-1:0];
        pidz_pkg::REG_EXIT_THR:  regs.exit_threshold <= cfg.data[pidz_pkg::ZONE_W-1:0];
        pidz_pkg::REG_TARGET:    regs.target_position <= cfg.data[pidz_pkg::POS_W-1:0];
      endcase
    end
  end

endmodule

// ----- hdl/pid_position_step_integral_zone_top.sv -----
// ----------------------------------------------------------------------------
// pid_position_step_integral_zone_top
// Position PID step with an integral zone: error, zoned and clamped integral,
// derivative, Q8.8 weighted sum, floor shift and saturated drive.
// ----------------------------------------------------------------------------
//
//   channel  dir   handshake      payload
//   cfg      in    valid/ready    index[2:0], data[23:0]
//   sample   in    valid/ready    position[23:0]
//   result   out   valid/ready    drive[7:0], at_target, error_value[24:0]
//
// one sample per cycle while the result side does not stall; a sample passes
// through the sample register, product register and result register
// the integral and previous error update as a word leaves the sample register,
// so the recurrence closes inside that stage
// a stalled result holds back one stage at a time; the stages in front keep
// filling, so sample.ready stays high until all three registers are full
// rst clears valids, integral and previous error, and loads the config registers with their reset values
module pid_position_step_integral_zone_top (
  input  logic          clk,
  input  logic          rst,
  pidz_cfg_if.sink      cfg,
  pidz_sample_if.sink   sample,
  pidz_result_if.source result
);

  pidz_pkg::cfg_t regs;

  pidz_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // stage occupancy and advance enables
  logic s_valid, p_valid, r_valid;
  logic r_free, p_free, s_free;

  assign r_free       = !r_valid || result.ready;
  assign p_free       = !p_valid || r_free;
  assign s_free       = !s_valid || p_free;
  assign sample.ready = s_free;

  // sample register
  logic signed [pidz_pkg::POS_W-1:0] position;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_free) begin
      s_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_free && sample.valid) begin
      position <= sample.position;
    end
  end

  // error, integral, derivative, products
  logic signed [pidz_pkg::ERR_W-1:0]    err;
  logic        [pidz_pkg::ERR_W-1:0]    mag;
  logic                                 in_zone;
  logic                                 reached;
  logic signed [pidz_pkg::INT_W-1:0]    integral;
  logic signed [pidz_pkg::INT_W-1:0]    integral_sum;
  logic signed [pidz_pkg::INT_W-1:0]    integral_lim;
  logic signed [pidz_pkg::INT_W-1:0]    integral_next;
  logic signed [pidz_pkg::ERR_W-1:0]    previous_error;
  logic signed [pidz_pkg::DER_W-1:0]    deriv;
  logic signed [pidz_pkg::PROD_P_W-1:0] prod_p_next;
  logic signed [pidz_pkg::PROD_I_W-1:0] prod_i_next;
  logic signed [pidz_pkg::PROD_D_W-1:0] prod_d_next;

  assign err = pidz_pkg::ERR_W'(regs.target_position) - pidz_pkg::ERR_W'(position);
  assign mag = err[pidz_pkg::ERR_W-1] ? pidz_pkg::ERR_W'(-err) : pidz_pkg::ERR_W'(err);

  assign in_zone = (err != '0) &&
                   (mag < pidz_pkg::ERR_W'(regs.integ_zone));
  assign reached = mag <= pidz_pkg::ERR_W'(regs.exit_threshold);

  // inside the zone the error magnitude is below the zone register, so it fits the integral width
  assign integral_sum = integral + err[pidz_pkg::INT_W-1:0];
  assign integral_lim = $signed(pidz_pkg::INT_W'(regs.integral_limit));

  always_comb begin
    if (!in_zone) begin
      integral_next = '0;
    end else if (integral_sum > integral_lim) begin
      integral_next = integral_lim;
    end else if (integral_sum < -integral_lim) begin
      integral_next = -integral_lim;
    end else begin
      integral_next = integral_sum;
    end
  end

  assign deriv = pidz_pkg::DER_W'(err) - pidz_pkg::DER_W'(previous_error);

  assign prod_p_next = pidz_pkg::PROD_P_W'($signed({1'b0, regs.gain_p})) *
                       pidz_pkg::PROD_P_W'(err);
  assign prod_i_next = pidz_pkg::PROD_I_W'($signed({1'b0, regs.gain_i})) *
                       pidz_pkg::PROD_I_W'(integral_next);
  assign prod_d_next = pidz_pkg::PROD_D_W'($signed({1'b0, regs.gain_d})) *
                       pidz_pkg::PROD_D_W'(deriv);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral       <= '0;
      previous_error <= '0;
    end else if (s_valid && p_free) begin
      integral       <= integral_next;
      previous_error <= err;
    end
  end

  // product register
  logic signed [pidz_pkg::PROD_P_W-1:0] prod_p;
  logic signed [pidz_pkg::PROD_I_W-1:0] prod_i;
  logic signed [pidz_pkg::PROD_D_W-1:0] prod_d;
  logic signed [pidz_pkg::ERR_W-1:0]    p_err;
  logic                                 p_reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && p_free) begin
      prod_p    <= prod_p_next;
      prod_i    <= prod_i_next;
      prod_d    <= prod_d_next;
      p_err     <= err;
      p_reached <= reached;
    end
  end

  // weighted sum, floor shift, saturation
  logic signed [pidz_pkg::ACC_W-1:0]   acc;
  logic signed [pidz_pkg::SHR_W-1:0]   shifted;
  logic signed [pidz_pkg::SHR_W-1:0]   out_lim;
  logic signed [pidz_pkg::SHR_W-1:0]   clamped;
  logic signed [pidz_pkg::DRIVE_W-1:0] drive_next;

  assign acc = pidz_pkg::ACC_W'(prod_p) + pidz_pkg::ACC_W'(prod_i) +
               pidz_pkg::ACC_W'(prod_d);
  assign shifted = acc[pidz_pkg::ACC_W-1:pidz_pkg::FRAC_W];
  assign out_lim = $signed(pidz_pkg::SHR_W'(regs.output_limit));

  always_comb begin
    if (shifted > out_lim) begin
      clamped = out_lim;
    end else if (shifted < -out_lim) begin
      clamped = -out_lim;
    end else begin
      clamped = shifted;
    end
  end

  assign drive_next = p_reached ? '0 : clamped[pidz_pkg::DRIVE_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_free) begin
      r_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && r_free) begin
      result.drive       <= drive_next;
      result.at_target   <= p_reached;
      result.error_value <= p_err;
    end
  end

  assign result.valid = r_valid;

endmodule
